FILE: rtl/iirdf1_pkg.sv
package iirdf1_pkg;

  localparam int MAX_ORDER      = 3;
  localparam int SAMPLE_WIDTH   = 16;
  localparam int COEF_WIDTH     = 24;
  localparam int COEF_FRAC_BITS = 20;
  localparam int NUM_REGS       = 8;
  localparam int REG_IDX_W      = $clog2(NUM_REGS);
  localparam int ORDER_W        = 2;

  // feedforward taps 0..MAX_ORDER, then feedback taps 1..MAX_ORDER
  localparam int NUM_TAPS = 2 * MAX_ORDER + 1;
  localparam int TAP_W    = $clog2(NUM_TAPS);
  localparam int HIST_W   = $clog2(MAX_ORDER + 1);

  localparam int PROD_W = COEF_WIDTH + SAMPLE_WIDTH;
  localparam int ACC_W  = PROD_W + $clog2(NUM_TAPS);
  localparam int SHR_W  = ACC_W - COEF_FRAC_BITS;

  localparam logic [TAP_W-1:0] FIRST_A_TAP = TAP_W'(MAX_ORDER + 1);
  localparam logic [TAP_W-1:0] LAST_B_TAP  = TAP_W'(MAX_ORDER);
  localparam logic [TAP_W-1:0] LAST_TAP    = TAP_W'(NUM_TAPS - 1);
  localparam logic [ORDER_W-1:0] ORDER_MAX = ORDER_W'(MAX_ORDER);

  localparam logic signed [SHR_W-1:0] SAT_MAX = SHR_W'((1 <<< (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [SHR_W-1:0] SAT_MIN = ~SAT_MAX;

  localparam logic [REG_IDX_W-1:0] REG_ORDER = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_B0    = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_B1    = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_B2    = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_B3    = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_A1    = REG_IDX_W'(5);
  localparam logic [REG_IDX_W-1:0] REG_A2    = REG_IDX_W'(6);
  localparam logic [REG_IDX_W-1:0] REG_A3    = REG_IDX_W'(7);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  typedef struct packed {
    logic             busy;
    logic             clr;
    logic             issue;
    logic [TAP_W-1:0] tap;
    logic             finish;
  } ctrl_t;

endpackage

FILE: rtl/iirdf1_mac.sv
module iirdf1_mac (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      clr,
  input  logic                                      issue,
  input  logic                                      sub,
  input  logic signed [iirdf1_pkg::COEF_WIDTH-1:0]   coef,
  input  logic signed [iirdf1_pkg::SAMPLE_WIDTH-1:0] smp,
  output logic signed [iirdf1_pkg::ACC_W-1:0]        acc
);
  import iirdf1_pkg::*;

  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     pvld_r, pvld_nxt;
  logic                     sub_r, sub_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;

  always_comb begin
    prod_nxt = PROD_W'(coef) * PROD_W'(smp);
    sub_nxt  = sub;
    pvld_nxt = issue & ~clr;
    acc_nxt  = acc_r;
    if (clr) begin
      acc_nxt = '0;
    end else if (pvld_r) begin
      if (sub_r) begin
        acc_nxt = acc_r - ACC_W'(prod_r);
      end else begin
        acc_nxt = acc_r + ACC_W'(prod_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
      acc_r  <= '0;
    end else begin
      pvld_r <= pvld_nxt;
      acc_r  <= acc_nxt;
    end
    prod_r <= prod_nxt;
    sub_r  <= sub_nxt;
  end

  assign acc = acc_r;

endmodule

FILE: rtl/iirdf1_ctrl.sv
module iirdf1_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_free,
  output iirdf1_pkg::ctrl_t ctrl
);
  import iirdf1_pkg::*;

  state_t           state_r, state_nxt;
  logic [TAP_W-1:0] tap_r, tap_nxt;
  logic             in_fire;

  assign in_fire = in_valid & (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    unique case (state_r)
      ST_IDLE: begin
        tap_nxt = '0;
        if (in_fire) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (tap_r == LAST_TAP) begin
          state_nxt = ST_DRAIN;
        end else begin
          tap_nxt = tap_r + TAP_W'(1);
        end
      end
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tap_r   <= '0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
    end
  end

  always_comb begin
    ctrl.busy   = (state_r != ST_IDLE);
    ctrl.clr    = in_fire;
    ctrl.issue  = (state_r == ST_RUN);
    ctrl.tap    = tap_r;
    ctrl.finish = (state_r == ST_DONE) & out_free;
  end

endmodule

FILE: rtl/iir_direct_form1_filter_top.sv
// Direct form I IIR filter of order 2 or 3 on signed 16-bit samples with signed
// Q4.20 coefficients. One shared multiply-accumulate unit walks all seven taps
// (b0..b3 on the input history, a1..a3 on the output history; taps beyond the
// programmed order contribute zero). From acceptance, each sample steps through
// the seven taps, drains the product register, and is shifted right by 20 and
// saturated as it is loaded into the output register. The input side stalls
// while a sample is in flight; a finished result waits in the output register
// and a new sample is accepted meanwhile. Order codes 0 and 1 act as order 2.
// The user writes coefficients and order through the cfg port only while the
// filter is idle, which the block does not enforce; both histories clear at reset.
module iir_direct_form1_filter_top (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic signed [iirdf1_pkg::SAMPLE_WIDTH-1:0] in_sample_in,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [iirdf1_pkg::SAMPLE_WIDTH-1:0] out_sample_out,
  output logic                                      out_saturated,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [iirdf1_pkg::REG_IDX_W-1:0]           cfg_index,
  input  logic [iirdf1_pkg::COEF_WIDTH-1:0]          cfg_wdata
);
  import iirdf1_pkg::*;

  ctrl_t ctrl;
  logic  in_fire, out_free, cfg_fire;

  logic [ORDER_W-1:0]           order_r;
  logic signed [COEF_WIDTH-1:0] coef_b_r [MAX_ORDER+1];
  logic signed [COEF_WIDTH-1:0] coef_a_r [MAX_ORDER];

  logic signed [SAMPLE_WIDTH-1:0] x_hist_r [MAX_ORDER+1];
  logic signed [SAMPLE_WIDTH-1:0] y_hist_r [MAX_ORDER];

  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r;
  logic                           out_sat_r;

  logic                           order_full, tap_is_a, tap_active;
  logic [HIST_W-1:0]              hidx;
  logic signed [COEF_WIDTH-1:0]   mac_coef;
  logic signed [SAMPLE_WIDTH-1:0] mac_smp;
  logic signed [ACC_W-1:0]        acc;
  logic signed [SHR_W-1:0]        shr;
  logic signed [SAMPLE_WIDTH-1:0] y_val;
  logic                           y_sat;

  assign in_stall  = ctrl.busy;
  assign in_fire   = in_valid & ~ctrl.busy;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  iirdf1_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_W'(2);
      for (int i = 0; i <= MAX_ORDER; i++) coef_b_r[i] <= '0;
      for (int i = 0; i < MAX_ORDER; i++) coef_a_r[i] <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_index) inside
        REG_ORDER: order_r <= cfg_wdata[ORDER_W-1:0];
        REG_B0, REG_B1, REG_B2, REG_B3: begin
          coef_b_r[HIST_W'(cfg_index - REG_B0)] <= cfg_wdata;
        end
        REG_A1, REG_A2, REG_A3: begin
          coef_a_r[HIST_W'(cfg_index - REG_A1)] <= cfg_wdata;
        end
        default: ;
      endcase
    end
  end

  // operand select for the current tap
  always_comb begin
    order_full = (order_r == ORDER_MAX);
    tap_is_a   = (ctrl.tap >= FIRST_A_TAP);
    hidx       = tap_is_a ? HIST_W'(ctrl.tap - FIRST_A_TAP) : HIST_W'(ctrl.tap);
    tap_active = order_full || ((ctrl.tap != LAST_B_TAP) && (ctrl.tap != LAST_TAP));
    if (tap_is_a) begin
      mac_coef = coef_a_r[hidx];
      mac_smp  = y_hist_r[hidx];
    end else begin
      mac_coef = coef_b_r[hidx];
      mac_smp  = x_hist_r[hidx];
    end
    if (!tap_active) mac_coef = '0;
  end

  iirdf1_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (ctrl.clr),
    .issue (ctrl.issue),
    .sub   (tap_is_a),
    .coef  (mac_coef),
    .smp   (mac_smp),
    .acc   (acc)
  );

  // scale and clip
  always_comb begin
    shr = $signed(acc[ACC_W-1:COEF_FRAC_BITS]);
    if (shr > SAT_MAX) begin
      y_val = SAMPLE_WIDTH'(SAT_MAX);
      y_sat = 1'b1;
    end else if (shr < SAT_MIN) begin
      y_val = SAMPLE_WIDTH'(SAT_MIN);
      y_sat = 1'b1;
    end else begin
      y_val = SAMPLE_WIDTH'(shr);
      y_sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= MAX_ORDER; i++) x_hist_r[i] <= '0;
      for (int i = 0; i < MAX_ORDER; i++) y_hist_r[i] <= '0;
    end else begin
      if (in_fire) begin
        for (int i = MAX_ORDER; i > 0; i--) x_hist_r[i] <= x_hist_r[i-1];
        x_hist_r[0] <= in_sample_in;
      end
      if (ctrl.finish) begin
        for (int i = MAX_ORDER - 1; i > 0; i--) y_hist_r[i] <= y_hist_r[i-1];
        y_hist_r[0] <= y_val;
      end
    end
  end

  // output transaction register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (ctrl.finish) begin
      out_sample_r <= y_val;
      out_sat_r    <= y_sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_saturated  = out_sat_r;

endmodule

FILE: rtl/iirdf1_chk.sv
module iirdf1_chk (
  input logic                                      clk,
  input logic                                      rst_n,
  input logic                                      in_valid,
  input logic                                      in_stall,
  input logic                                      out_valid,
  input logic                                      out_stall,
  input logic signed [iirdf1_pkg::SAMPLE_WIDTH-1:0] out_sample_out,
  input logic                                      out_saturated
);
  import iirdf1_pkg::*;

  logic in_fire;
  assign in_fire = in_valid & ~in_stall;

  // a transaction in flight blocks the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_stall)
    else $error("input not stalled after accept");

  // a new result only comes out of a sample in flight
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work in flight");

  // clipping flag matches a rail value
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_sample_out == SAMPLE_WIDTH'(SAT_MAX) || out_sample_out == SAMPLE_WIDTH'(SAT_MIN)))
    else $error("saturated flag on non-rail value");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_sample_out) && $stable(out_saturated)))
    else $error("stalled result changed");

endmodule

bind iir_direct_form1_filter_top iirdf1_chk u_iirdf1_chk (.*);

FILE: test/iir_direct_form1_filter_top_test.sv
`timescale 1ns / 1ps

module iir_direct_form1_filter_top_test;
  import iirdf1_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_SEGMENTS = 8;
  localparam int SEGMENT_ITEMS   = 84;
  localparam int MAX_REPORTS     = 10;

  localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_HI = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_LO = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

  localparam logic [COEF_WIDTH-1:0] COEF_ONE     = COEF_WIDTH'(1 << COEF_FRAC_BITS);
  localparam logic [COEF_WIDTH-1:0] COEF_HALF    = COEF_WIDTH'(1 << (COEF_FRAC_BITS - 1));
  localparam logic [COEF_WIDTH-1:0] COEF_QUARTER = COEF_WIDTH'(1 << (COEF_FRAC_BITS - 2));
  localparam logic [COEF_WIDTH-1:0] COEF_EIGHTH  = COEF_WIDTH'(1 << (COEF_FRAC_BITS - 3));
  localparam logic [COEF_WIDTH-1:0] COEF_POS_MAX = {1'b0, {(COEF_WIDTH - 1){1'b1}}};
  localparam logic [COEF_WIDTH-1:0] COEF_NEG_MAX = {1'b1, {(COEF_WIDTH - 1){1'b0}}};

  typedef struct packed {
    logic [ORDER_W-1:0]                 order;
    logic [MAX_ORDER:0][COEF_WIDTH-1:0] b;
    logic [MAX_ORDER:0][COEF_WIDTH-1:0] a;
  } filt_cfg_t;

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] sample;
    logic                    sat;
  } filt_out_t;

  logic                           clk            = 1'b0;
  logic                           rst_n          = 1'b0;
  logic                           in_valid       = 1'b0;
  logic                           in_stall;
  logic signed [SAMPLE_WIDTH-1:0] in_sample_in   = '0;
  logic                           out_valid;
  logic                           out_stall      = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_out;
  logic                           out_saturated;
  logic                           cfg_valid      = 1'b0;
  logic                           cfg_ready;
  logic [REG_IDX_W-1:0]           cfg_index      = '0;
  logic [COEF_WIDTH-1:0]          cfg_wdata      = '0;

  filt_cfg_t                      active_cfg;
  logic signed [SAMPLE_WIDTH-1:0] x_hist [MAX_ORDER + 1] = '{default: '0};
  logic signed [SAMPLE_WIDTH-1:0] y_hist [MAX_ORDER]     = '{default: '0};
  filt_out_t                      expected_outputs [$];
  filt_out_t                      want;

  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int mismatch_count  = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int sat_results     = 0;
  int configs_loaded  = 0;
  int cycle_count     = 0;

  iir_direct_form1_filter_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_out(out_sample_out),
    .out_saturated (out_saturated),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_outputs.size());
      $display("iir_direct_form1_filter_top verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic filt_out_t filter_step(logic signed [SAMPLE_WIDTH-1:0] s);
    int        taps;
    longint    acc;
    longint    y;
    filt_out_t r;
    taps = (active_cfg.order < 2) ? 2 : int'(active_cfg.order);
    if (taps > MAX_ORDER) taps = MAX_ORDER;
    for (int k = MAX_ORDER; k > 0; k--) x_hist[k] = x_hist[k - 1];
    x_hist[0] = s;
    acc = 0;
    for (int k = 0; k <= taps; k++)
      acc += longint'($signed(active_cfg.b[k])) * longint'(x_hist[k]);
    for (int k = 1; k <= taps; k++)
      acc -= longint'($signed(active_cfg.a[k])) * longint'(y_hist[k - 1]);
    y = acc >>> COEF_FRAC_BITS;
    r.sat = 1'b0;
    if (y > SAMPLE_MAX) begin
      y = SAMPLE_MAX;
      r.sat = 1'b1;
    end else if (y < SAMPLE_MIN) begin
      y = SAMPLE_MIN;
      r.sat = 1'b1;
    end
    r.sample = y[SAMPLE_WIDTH-1:0];
    for (int k = MAX_ORDER - 1; k > 0; k--) y_hist[k] = y_hist[k - 1];
    y_hist[0] = r.sample;
    return r;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  // one transaction per accepted result, checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (expected_outputs.size() == 0) begin
        note_mismatch($sformatf("unexpected result sample %0d saturated %0b",
                                out_sample_out, out_saturated));
      end else begin
        want = expected_outputs.pop_front();
        if (want.sat) sat_results++;
        if (out_sample_out !== want.sample || out_saturated !== want.sat)
          note_mismatch($sformatf(
            "result %0d expected sample %0d saturated %0b, got sample %0d saturated %0b",
            results_checked, $signed(want.sample), want.sat, out_sample_out,
            out_saturated));
      end
    end
  end

  function automatic logic [COEF_WIDTH-1:0] reg_data(filt_cfg_t c,
                                                     logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_ORDER: return (COEF_WIDTH'($urandom) & ~COEF_WIDTH'(3)) | COEF_WIDTH'(c.order);
      REG_B0:    return c.b[0];
      REG_B1:    return c.b[1];
      REG_B2:    return c.b[2];
      REG_B3:    return c.b[3];
      REG_A1:    return c.a[1];
      REG_A2:    return c.a[2];
      REG_A3:    return c.a[3];
      default:   return '0;
    endcase
  endfunction

  task automatic load_config(filt_cfg_t c);
    logic [REG_IDX_W-1:0] idx;
    for (int i = 0; i < NUM_REGS; i++) begin
      idx = REG_IDX_W'(i);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= reg_data(c, idx);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    active_cfg = c;
    configs_loaded++;
  endtask

  task automatic send_sample(logic signed [SAMPLE_WIDTH-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid     <= 1'b0;
      in_sample_in <= SAMPLE_WIDTH'($urandom);
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_outputs.push_back(filter_step(s));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(negedge clk);
  endtask

  function automatic logic [COEF_WIDTH-1:0] pick_coef(int style, int lim);
    case (style)
      0: return COEF_WIDTH'(int'($urandom_range(0, 2 * lim)) - lim);
      1: return COEF_WIDTH'($urandom);
      default: begin
        case ($urandom_range(3))
          0:       return COEF_POS_MAX;
          1:       return COEF_NEG_MAX;
          2:       return '0;
          default: return COEF_WIDTH'($urandom);
        endcase
      end
    endcase
  endfunction

  function automatic filt_cfg_t random_cfg();
    filt_cfg_t c;
    int        sel;
    int        style;
    sel = $urandom_range(4);
    style = (sel < 3) ? 0 : sel - 2;
    c.order = ORDER_W'($urandom_range(3));
    for (int k = 0; k <= MAX_ORDER; k++) begin
      c.b[k] = pick_coef(style, 1 << (COEF_FRAC_BITS - 1));
      c.a[k] = pick_coef(style, 1 << (COEF_FRAC_BITS - 2));
    end
    return c;
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
    case ($urandom_range(15))
      0:       return SAMPLE_HI;
      1:       return SAMPLE_LO;
      2:       return '0;
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  task automatic test_reset_state();
    send_sample(SAMPLE_HI);
    send_sample(SAMPLE_LO);
  endtask

  task automatic test_passthrough();
    filt_cfg_t c;
    c = '0;
    c.order = ORDER_W'(2);
    c.b[0] = COEF_ONE;
    wait_idle();
    load_config(c);
    send_sample(SAMPLE_HI);
    send_sample(SAMPLE_LO);
    send_sample('0);
    send_sample(SAMPLE_WIDTH'(1));
    send_sample(SAMPLE_WIDTH'(-1));
    // half gain shows rounding toward minus infinity
    c.b[0] = COEF_HALF;
    wait_idle();
    load_config(c);
    send_sample(SAMPLE_WIDTH'(-1));
    send_sample(SAMPLE_WIDTH'(1));
  endtask

  task automatic test_clipping();
    filt_cfg_t c;
    c = '0;
    c.order = ORDER_W'(2);
    c.b[0] = COEF_POS_MAX;
    wait_idle();
    load_config(c);
    send_sample(SAMPLE_HI);
    send_sample(SAMPLE_LO);
    send_sample(SAMPLE_WIDTH'(4096));
    send_sample(SAMPLE_WIDTH'(-4096));
  endtask

  task automatic test_order_codes();
    filt_cfg_t c;
    c = '0;
    c.b[0] = COEF_HALF;
    c.b[1] = COEF_QUARTER;
    c.b[2] = -COEF_QUARTER;
    c.b[3] = COEF_HALF + COEF_QUARTER;
    c.a[1] = COEF_HALF;
    c.a[2] = -COEF_QUARTER;
    c.a[3] = COEF_EIGHTH;
    for (int ord = 0; ord < 4; ord++) begin
      c.order = ORDER_W'(ord);
      wait_idle();
      load_config(c);
      send_sample(SAMPLE_WIDTH'(20000));
      send_sample(SAMPLE_WIDTH'(-15000));
      send_sample(SAMPLE_WIDTH'(7000));
    end
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (RANDOM_SEGMENTS) begin
      wait_idle();
      load_config(random_cfg());
      repeat (SEGMENT_ITEMS) send_sample(pick_sample());
    end
  endtask

  initial begin
    active_cfg = '0;
    active_cfg.order = ORDER_W'(2);
    send_idle_pct  = 35;
    recv_stall_pct = 62;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_state();
    test_passthrough();
    test_clipping();
    test_order_codes();
    test_random_traffic(35, 62);
    test_random_traffic(62, 35);
    test_random_traffic(0, 0);

    wait_idle();
    repeat (30) @(negedge clk);
    $display("covered %0d samples and %0d results over %0d coefficient sets, orders 0 to 3",
             items_sent, results_checked, configs_loaded);
    $display("%0d results were clipped, %0d mismatches seen", sat_results, mismatch_count);
    if (mismatch_count == 0) begin
      $display("iir_direct_form1_filter_top verification clean");
    end else begin
      $display("iir_direct_form1_filter_top verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/iirdf1_pkg.sv
rtl/iirdf1_mac.sv
rtl/iirdf1_ctrl.sv
rtl/iir_direct_form1_filter_top.sv
rtl/iirdf1_chk.sv
test/iir_direct_form1_filter_top_test.sv
